/* src/vrpt_pkg.sv */
package vrpt_pkg;

  localparam int OAM_DEPTH     = 256;
  localparam int PALETTE_DEPTH = 32;
  localparam int VBLANK_LINE   = 241;

  // register selects
  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_OAMADDR = 3'd3;
  localparam logic [2:0] REG_OAMDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  // op codes on the input port
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_ACK   = 3'd3;
  localparam logic [2:0] OP_LOAD  = 3'd4;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_READ,
    CMD_ACK,
    CMD_LOAD,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  reg_sel;
    logic [7:0]  wdata;
    logic [7:0]  tick_cycles;
    logic [12:0] chr_index;
  } cmd_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       frame_done;
    logic       nmi_pending;
  } res_t;

endpackage

/* src/vrpt_fifo.sv */
module vrpt_fifo import vrpt_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end
endmodule

/* src/vrpt_front.sv */
module vrpt_front import vrpt_pkg::*; (
  input  logic [2:0]  op,
  input  logic [2:0]  reg_sel,
  input  logic [7:0]  wdata,
  input  logic [7:0]  tick_cycles,
  input  logic [12:0] chr_index,
  output cmd_t        cmd
);
  // classify the op (a zero tick becomes a no-op); every operand field passes through for all kinds
  always_comb begin
    cmd             = '0;
    cmd.reg_sel     = reg_sel;
    cmd.wdata       = wdata;
    cmd.tick_cycles = tick_cycles;
    cmd.chr_index   = chr_index;
    case (op)
      OP_TICK:  cmd.kind = (tick_cycles == 8'd0) ? CMD_NOP : CMD_TICK;
      OP_WRITE: cmd.kind = CMD_WRITE;
      OP_READ:  cmd.kind = CMD_READ;
      OP_ACK:   cmd.kind = CMD_ACK;
      OP_LOAD:  cmd.kind = CMD_LOAD;
      default:  cmd.kind = CMD_NOP;
    endcase
  end
endmodule

/* src/vrpt_back.sv */
module vrpt_back import vrpt_pkg::*; #(
  parameter int VRAM_DEPTH      = 2048,
  parameter int CHR_DEPTH       = 8192,
  parameter int DOTS_PER_LINE   = 341,
  parameter int LINES_PER_FRAME = 262
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       cmd_empty,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  input  logic       res_full,
  output logic       res_push,
  output res_t       res,
  output logic       clearing
);
  localparam int NT_AW  = $clog2(VRAM_DEPTH);
  localparam int CHR_AW = $clog2(CHR_DEPTH);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_FIN} state_t;

  state_t state;
  logic [NT_AW-1:0] clr_addr;

  logic [1:0]  mirroring_mode;
  cmd_t        cur;
  logic [7:0]  ctrl, mask, sprite_index, scroll_x, scroll_y, read_buffer;
  logic        vblank, sprite_zero, nmi, addr_latch, scroll_latch;
  logic [13:0] vram_address;
  logic [8:0]  dot_count, line_count;
  logic [7:0]  s0, s3;
  logic [7:0]  palette [PALETTE_DEPTH];

  logic [7:0]  ctrl_next, mask_next, sprite_index_next, scroll_x_next, scroll_y_next;
  logic [7:0]  read_buffer_next;
  logic        vblank_next, sprite_zero_next, nmi_next, addr_latch_next, scroll_latch_next;
  logic [13:0] vram_address_next;
  logic [8:0]  dot_count_next, line_count_next;

  logic [7:0] nt_mem  [VRAM_DEPTH];
  logic [7:0] chr_mem [CHR_DEPTH];
  logic [7:0] oam_mem [OAM_DEPTH];
  logic [OAM_DEPTH-1:0] oam_vld;
  logic [7:0] nt_q, chr_q, oam_q;
  logic       oam_vld_q;

  logic             start;
  logic [NT_AW-1:0] nt_idx;
  logic [CHR_AW-1:0] chr_rd_idx, chr_ld_idx;
  logic [4:0]       pal_idx;
  logic             nt_we, pal_we, chr_we, oam_we;
  logic [13:0]      vram_step;
  logic [9:0]       dot_sum;
  logic [9:0]       line_inc;

  function automatic logic [NT_AW-1:0] nt_map(logic [13:0] a, logic [1:0] mode);
    logic [12:0] idx;
    idx = {1'b0, a[11:0]};
    if (mode == 2'd1) begin
      if (idx[11]) idx = idx - 13'h800;
    end else if (mode == 2'd0) begin
      if (idx[11:10] == 2'd1 || idx[11:10] == 2'd2) idx = idx - 13'h400;
      else if (idx[11:10] == 2'd3) idx = idx - 13'h800;
    end
    if (idx >= 13'(VRAM_DEPTH)) idx = idx - 13'(VRAM_DEPTH);
    return idx[NT_AW-1:0];
  endfunction

  // operand below 8192 and depth at least 2048: three folds at most
  function automatic logic [CHR_AW-1:0] chr_wrap(logic [12:0] a);
    logic [13:0] v;
    v = {1'b0, a};
    for (int i = 0; i < 3; i++) begin
      if (v >= 14'(CHR_DEPTH)) v = v - 14'(CHR_DEPTH);
    end
    return v[CHR_AW-1:0];
  endfunction

  assign clearing   = (state == ST_CLEAR);
  assign start      = (state == ST_IDLE) && !cmd_empty && !res_full;
  assign cmd_pop    = start;
  assign res_push   = (state == ST_FIN);
  assign nt_idx     = nt_map(vram_address, mirroring_mode);
  assign chr_rd_idx = chr_wrap(vram_address[12:0]);
  assign chr_ld_idx = chr_wrap(cur.chr_index);
  assign pal_idx    = {vram_address[4] & (vram_address[1:0] != 2'b00), vram_address[3:0]};
  assign vram_step  = vram_address + (ctrl[2] ? 14'd32 : 14'd1);
  assign dot_sum    = {1'b0, dot_count} + {2'b0, cur.tick_cycles};
  assign line_inc   = {1'b0, line_count} + 10'd1;

  always_comb begin
    ctrl_next         = ctrl;
    mask_next         = mask;
    sprite_index_next = sprite_index;
    scroll_x_next     = scroll_x;
    scroll_y_next     = scroll_y;
    read_buffer_next  = read_buffer;
    vblank_next       = vblank;
    sprite_zero_next  = sprite_zero;
    nmi_next          = nmi;
    addr_latch_next   = addr_latch;
    scroll_latch_next = scroll_latch;
    vram_address_next = vram_address;
    dot_count_next    = dot_count;
    line_count_next   = line_count;
    nt_we             = 1'b0;
    pal_we            = 1'b0;
    chr_we            = 1'b0;
    oam_we            = 1'b0;
    res               = '0;
    case (cur.kind)
      CMD_TICK: begin
        if (dot_sum >= 10'(DOTS_PER_LINE)) begin
          if ({1'b0, s0} == line_count && {2'b0, s3} <= dot_sum && mask[4]) begin
            sprite_zero_next = 1'b1;
          end
          dot_count_next = 9'(dot_sum - 10'(DOTS_PER_LINE));
          line_count_next = line_inc[8:0];
          if (line_inc == 10'(VBLANK_LINE)) begin
            vblank_next      = 1'b1;
            sprite_zero_next = 1'b0;
            if (ctrl[7]) nmi_next = 1'b1;
          end
          if (line_inc >= 10'(LINES_PER_FRAME)) begin
            line_count_next  = '0;
            nmi_next         = 1'b0;
            sprite_zero_next = 1'b0;
            vblank_next      = 1'b0;
            res.frame_done   = 1'b1;
          end
        end else begin
          dot_count_next = dot_sum[8:0];
        end
      end
      CMD_WRITE: begin
        case (cur.reg_sel)
          REG_CTRL: begin
            ctrl_next = cur.wdata;
            if (!ctrl[7] && cur.wdata[7] && vblank) nmi_next = 1'b1;
          end
          REG_MASK:    mask_next = cur.wdata;
          REG_OAMADDR: sprite_index_next = cur.wdata;
          REG_OAMDATA: begin
            oam_we            = 1'b1;
            sprite_index_next = sprite_index + 8'd1;
          end
          REG_SCROLL: begin
            if (scroll_latch) scroll_y_next = cur.wdata;
            else scroll_x_next = cur.wdata;
            scroll_latch_next = !scroll_latch;
          end
          REG_ADDR: begin
            if (!addr_latch) vram_address_next = {cur.wdata[5:0], vram_address[7:0]};
            else vram_address_next = {vram_address[13:8], cur.wdata};
            addr_latch_next = !addr_latch;
          end
          REG_DATA: begin
            if (vram_address[13:12] == 2'b10) nt_we = 1'b1;
            else if (vram_address[13:8] == 6'h3f) pal_we = 1'b1;
            vram_address_next = vram_step;
          end
          default: ;
        endcase
      end
      CMD_READ: begin
        case (cur.reg_sel)
          REG_STATUS: begin
            res.rdata         = {vblank, sprite_zero, 6'b0};
            vblank_next       = 1'b0;
            addr_latch_next   = 1'b0;
            scroll_latch_next = 1'b0;
          end
          REG_OAMDATA: res.rdata = oam_vld_q ? oam_q : 8'd0;
          REG_DATA: begin
            vram_address_next = vram_step;
            if (!vram_address[13]) begin
              res.rdata        = read_buffer;
              read_buffer_next = chr_q;
            end else if (!vram_address[12]) begin
              res.rdata        = read_buffer;
              read_buffer_next = nt_q;
            end else if (vram_address[13:8] == 6'h3f) begin
              res.rdata = palette[pal_idx];
            end
          end
          default: ;
        endcase
      end
      CMD_ACK:  nmi_next = 1'b0;
      CMD_LOAD: chr_we = 1'b1;
      default: ;
    endcase
    res.nmi_pending = nmi_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      mirroring_mode <= '0;
      ctrl           <= '0;
      mask           <= '0;
      sprite_index   <= '0;
      scroll_x       <= '0;
      scroll_y       <= '0;
      read_buffer    <= '0;
      vblank         <= 1'b0;
      sprite_zero    <= 1'b0;
      nmi            <= 1'b0;
      addr_latch     <= 1'b0;
      scroll_latch   <= 1'b0;
      vram_address   <= '0;
      dot_count      <= '0;
      line_count     <= '0;
      s0             <= '0;
      s3             <= '0;
      oam_vld        <= '0;
      for (int i = 0; i < PALETTE_DEPTH; i++) palette[i] <= '0;
    end else begin
      if (cfg_we) mirroring_mode <= cfg_wdata;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == NT_AW'(VRAM_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) state <= ST_FIN;
        end
        ST_FIN: begin
          state        <= ST_IDLE;
          ctrl         <= ctrl_next;
          mask         <= mask_next;
          sprite_index <= sprite_index_next;
          scroll_x     <= scroll_x_next;
          scroll_y     <= scroll_y_next;
          read_buffer  <= read_buffer_next;
          vblank       <= vblank_next;
          sprite_zero  <= sprite_zero_next;
          nmi          <= nmi_next;
          addr_latch   <= addr_latch_next;
          scroll_latch <= scroll_latch_next;
          vram_address <= vram_address_next;
          dot_count    <= dot_count_next;
          line_count   <= line_count_next;
          if (oam_we) begin
            oam_vld[sprite_index] <= 1'b1;
            if (sprite_index == 8'd0) s0 <= cur.wdata;
            if (sprite_index == 8'd3) s3 <= cur.wdata;
          end
          if (pal_we) palette[pal_idx] <= cur.wdata;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // command hold and synchronous memory reads, issued on the start cycle
  always_ff @(posedge clk) begin
    if (start) begin
      cur       <= cmd;
      nt_q      <= nt_mem[nt_idx];
      chr_q     <= chr_mem[chr_rd_idx];
      oam_q     <= oam_mem[sprite_index];
      oam_vld_q <= oam_vld[sprite_index];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      nt_mem[clr_addr] <= '0;
    end else if (state == ST_FIN && nt_we) begin
      nt_mem[nt_idx] <= cur.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && chr_we) chr_mem[chr_ld_idx] <= cur.wdata;
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && oam_we) oam_mem[sprite_index] <= cur.wdata;
  end
endmodule

/* src/video_register_port_timing_core.sv */
// Picture-unit register port with scanline timing.
// Input channel: present op/reg_sel/wdata/tick_cycles/chr_index with push;
//   a word is taken at an edge where push is high and full is low.
// Result channel: while empty is low the oldest result word (rdata,
//   frame_done, nmi_pending) is on the ports; pop at an edge takes it.
//   Every input word yields exactly one result word, in order.
// Config: mirroring_we writes mirroring_mode (0 horiz, 1 vert, 2 four-screen);
//   write it only while the block is idle.
// Execution: the execute unit handles one word at a time: a read step
//   issues the synchronous name-table / character / sprite reads, then an
//   update step updates state and pushes the result.
// An accepted word passes the read step, taken while the word heads the
//   command queue, then the update step, before empty goes low.
// Reset (rst, synchronous): the picture-unit registers and flags clear; full
//   stays high while the name-table memory is swept to zero.
// Stalls: a 2-word command queue and a 2-word result queue decouple the
//   sides; if the result queue fills, execution waits and the command queue
//   backs up into full.
module video_register_port_timing_core import vrpt_pkg::*; #(
  parameter int VRAM_DEPTH      = 2048,
  parameter int CHR_DEPTH       = 8192,
  parameter int DOTS_PER_LINE   = 341,
  parameter int LINES_PER_FRAME = 262
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op,
  input  logic [2:0]  reg_sel,
  input  logic [7:0]  wdata,
  input  logic [7:0]  tick_cycles,
  input  logic [12:0] chr_index,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  rdata,
  output logic        frame_done,
  output logic        nmi_pending,
  input  logic        mirroring_we,
  input  logic [1:0]  mirroring_mode
);
  cmd_t cmd_in, cmd_head;
  res_t res_in, res_head;
  logic cmd_full, cmd_empty, cmd_pop;
  logic res_full, res_push;
  logic clearing;

  // input side is closed during the post-reset memory sweep
  assign full = cmd_full || clearing;

  vrpt_front u_front (
    .op          (op),
    .reg_sel     (reg_sel),
    .wdata       (wdata),
    .tick_cycles (tick_cycles),
    .chr_index   (chr_index),
    .cmd         (cmd_in)
  );

  vrpt_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !clearing),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  vrpt_back #(
    .VRAM_DEPTH      (VRAM_DEPTH),
    .CHR_DEPTH       (CHR_DEPTH),
    .DOTS_PER_LINE   (DOTS_PER_LINE),
    .LINES_PER_FRAME (LINES_PER_FRAME)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (mirroring_we),
    .cfg_wdata (mirroring_mode),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .clearing  (clearing)
  );

  vrpt_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign rdata       = res_head.rdata;
  assign frame_done  = res_head.frame_done;
  assign nmi_pending = res_head.nmi_pending;
endmodule

/* dv/video_register_port_timing_core_tb.sv */
module video_register_port_timing_core_tb;
  import vrpt_pkg::*;

  // Local copies of the block's sizes and address map
  localparam int NT_DEPTH    = 2048;
  localparam int CHR_SIZE    = 8192;
  localparam int LINE_DOTS   = 341;
  localparam int FRAME_LINES = 262;
  localparam int SETTLE      = 8;   // cycles past the last result before a config write

  // op codes 5..7 carry no meaning; the block must treat them as no-ops
  localparam logic [2:0] OP_SPARE = 3'd5;

  localparam logic [1:0] MIR_HORIZ = 2'd0;
  localparam logic [1:0] MIR_VERT  = 2'd1;
  localparam logic [1:0] MIR_FOUR  = 2'd2;
  localparam logic [1:0] MIR_NONE  = 2'd3;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [2:0]  op;
  logic [2:0]  reg_sel;
  logic [7:0]  wdata;
  logic [7:0]  tick_cycles;
  logic [12:0] chr_index;
  logic        empty;
  logic        pop;
  logic [7:0]  rdata;
  logic        frame_done;
  logic        nmi_pending;
  logic        mirroring_we;
  logic [1:0]  mirroring_mode;

  video_register_port_timing_core DUT (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .op             (op),
    .reg_sel        (reg_sel),
    .wdata          (wdata),
    .tick_cycles    (tick_cycles),
    .chr_index      (chr_index),
    .empty          (empty),
    .pop            (pop),
    .rdata          (rdata),
    .frame_done     (frame_done),
    .nmi_pending    (nmi_pending),
    .mirroring_we   (mirroring_we),
    .mirroring_mode (mirroring_mode)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the picture unit, updated once per accepted word
  // ---------------------------------------------------------------------------
  logic [1:0]  mir_sel;
  logic [7:0]  ctrl_r, mask_r, oam_ptr, scroll_x_r, scroll_y_r, data_buf;
  bit          vblank, spr0_hit, nmi_req, addr_lo_next, scroll_y_next;
  logic [13:0] vaddr;
  logic [7:0]  oam_mem [256];
  logic [7:0]  nt_mem  [NT_DEPTH];
  logic [7:0]  pal_mem [32];
  logic [7:0]  chr_mem [CHR_SIZE];
  bit          chr_known [CHR_SIZE];
  int unsigned dot_cnt, line_cnt;
  int unsigned frames_seen;

  res_t        expected_words [$];
  int          errors;
  bit          quiet;             // when set, neither side inserts gaps

  function automatic int unsigned nt_slot(int unsigned a);
    int unsigned idx;
    int unsigned tbl;
    idx = (a & 'h2fff) - 'h2000;
    tbl = idx / 'h400;
    if (mir_sel == MIR_VERT) begin
      if (tbl == 2 || tbl == 3) idx -= 'h800;
    end else if (mir_sel == MIR_HORIZ) begin
      if (tbl == 1 || tbl == 2) idx -= 'h400;
      else if (tbl == 3) idx -= 'h800;
    end
    return idx % NT_DEPTH;
  endfunction

  function automatic int unsigned pal_slot(int unsigned a);
    int unsigned idx;
    idx = (a - 'h3f00) % 32;
    if ((idx & 'h13) == 'h10) idx -= 'h10;
    return idx;
  endfunction

  function automatic void bump_vaddr();
    vaddr = vaddr + (ctrl_r[2] ? 14'd32 : 14'd1);
  endfunction

  // Apply one word to the shadow state and return the result it should produce
  function automatic res_t predict_word(logic [2:0] o, logic [2:0] s, logic [7:0] d,
                                        logic [7:0] t, logic [12:0] ci);
    res_t        r;
    int unsigned a;
    r = '0;
    case (o)
      OP_TICK: begin
        dot_cnt += t;
        if (dot_cnt >= LINE_DOTS) begin
          // sprite-zero test uses the line and dot count before the wrap
          if (oam_mem[0] == line_cnt && oam_mem[3] <= dot_cnt && mask_r[4])
            spr0_hit = 1'b1;
          dot_cnt -= LINE_DOTS;
          line_cnt += 1;
          if (line_cnt == VBLANK_LINE) begin
            vblank   = 1'b1;
            spr0_hit = 1'b0;
            if (ctrl_r[7]) nmi_req = 1'b1;
          end
          if (line_cnt >= FRAME_LINES) begin
            line_cnt     = 0;
            nmi_req      = 1'b0;
            spr0_hit     = 1'b0;
            vblank       = 1'b0;
            r.frame_done = 1'b1;
            frames_seen++;
          end
        end
      end
      OP_WRITE: begin
        case (s)
          REG_CTRL: begin
            // enabling NMI inside vblank raises the request at once
            if (!ctrl_r[7] && d[7] && vblank) nmi_req = 1'b1;
            ctrl_r = d;
          end
          REG_MASK:    mask_r = d;
          REG_OAMADDR: oam_ptr = d;
          REG_OAMDATA: begin
            oam_mem[oam_ptr] = d;
            oam_ptr++;
          end
          REG_SCROLL: begin
            if (scroll_y_next) scroll_y_r = d; else scroll_x_r = d;
            scroll_y_next = !scroll_y_next;
          end
          REG_ADDR: begin
            if (!addr_lo_next) vaddr = {d[5:0], vaddr[7:0]};
            else vaddr = {vaddr[13:8], d};
            addr_lo_next = !addr_lo_next;
          end
          REG_DATA: begin
            a = vaddr;
            if (a >= 'h2000 && a <= 'h2fff) nt_mem[nt_slot(a)] = d;
            else if (a >= 'h3f00) pal_mem[pal_slot(a)] = d;
            bump_vaddr();
          end
          default: ;
        endcase
      end
      OP_READ: begin
        case (s)
          REG_STATUS: begin
            r.rdata       = {vblank, spr0_hit, 6'd0};
            vblank        = 1'b0;
            addr_lo_next  = 1'b0;
            scroll_y_next = 1'b0;
          end
          REG_OAMDATA: r.rdata = oam_mem[oam_ptr];
          REG_DATA: begin
            a = vaddr;
            bump_vaddr();
            if (a <= 'h1fff) begin
              r.rdata  = data_buf;
              data_buf = chr_mem[a];
            end else if (a <= 'h2fff) begin
              r.rdata  = data_buf;
              data_buf = nt_mem[nt_slot(a)];
            end else if (a >= 'h3f00) begin
              r.rdata = pal_mem[pal_slot(a)];
            end
          end
          default: ;
        endcase
      end
      OP_ACK: nmi_req = 1'b0;
      OP_LOAD: begin
        chr_mem[ci]   = d;
        chr_known[ci] = 1'b1;
      end
      default: ;
    endcase
    r.nmi_pending = nmi_req;
    return r;
  endfunction

  // Mostly short gaps, some long, none while quiet is set
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one word per call, prediction at the accepting edge
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [2:0] o, logic [2:0] s, logic [7:0] d,
                           logic [7:0] t, logic [12:0] ci);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    op          <= o;
    reg_sel     <= s;
    wdata       <= d;
    tick_cycles <= t;
    chr_index   <= ci;
    do @(posedge clk); while (full);
    expected_words.push_back(predict_word(o, s, d, t, ci));
  endtask

  task automatic reg_write(logic [2:0] s, logic [7:0] d);
    send_word(OP_WRITE, s, d, 8'($urandom), 13'($urandom));
  endtask

  task automatic reg_read(logic [2:0] s);
    send_word(OP_READ, s, 8'($urandom), 8'($urandom), 13'($urandom));
  endtask

  task automatic tick(logic [7:0] n);
    send_word(OP_TICK, 3'($urandom), 8'($urandom), n, 13'($urandom));
  endtask

  task automatic set_vaddr(logic [13:0] a);
    // status read first so the address latch is known to be on the high byte
    reg_read(REG_STATUS);
    reg_write(REG_ADDR, {2'($urandom_range(0, 3)), a[13:8]});
    reg_write(REG_ADDR, a[7:0]);
  endtask

  // Data-port read; never lets the buffer pick up a character byte never loaded
  task automatic data_read();
    if (vaddr <= 14'h1fff && !chr_known[vaddr[12:0]])
      send_word(OP_LOAD, 3'($urandom), 8'($urandom), 8'($urandom), vaddr[12:0]);
    reg_read(REG_DATA);
  endtask

  // Hold the sender until every word in flight has come back
  task automatic drain();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mirroring(logic [1:0] m);
    drain();
    mirroring_we   <= 1'b1;
    mirroring_mode <= m;
    @(posedge clk);
    mirroring_we   <= 1'b0;
    mir_sel = m;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop stalls, compare against the oldest expectation
  // ---------------------------------------------------------------------------
  int pop_hold;

  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: rdata=%0h", rdata);
          errors++;
        end else begin
          res_t w;
          w = expected_words.pop_front();
          if (rdata !== w.rdata) begin
            $error("rdata expected %0h got %0h", w.rdata, rdata);
            errors++;
          end
          if (frame_done !== w.frame_done) begin
            $error("frame_done expected %0b got %0b", w.frame_done, frame_done);
            errors++;
          end
          if (nmi_pending !== w.nmi_pending) begin
            $error("nmi_pending expected %0b got %0b", w.nmi_pending, nmi_pending);
            errors++;
          end
        end
      end
      if (pop_hold > 0) begin
        pop      <= 1'b0;
        pop_hold <= pop_hold - 1;
      end else begin
        pop      <= 1'b1;
        pop_hold <= pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corners of each register and each op, one or two words apiece
  task automatic test_directed();
    send_word(OP_ACK, 3'($urandom), 8'($urandom), 8'($urandom), 13'($urandom));
    send_word(OP_SPARE, 3'd7, 8'hff, 8'hff, 13'h1fff);
    send_word(OP_SPARE + 3'd2, 3'd0, 8'h00, 8'h00, 13'h0000);
    tick(8'd0);                          // zero dots changes nothing
    tick(8'd255);
    send_word(OP_LOAD, 3'($urandom), 8'hc3, 8'($urandom), 13'h1fff);
    send_word(OP_LOAD, 3'($urandom), 8'h3c, 8'($urandom), 13'h0000);
    reg_write(REG_STATUS, 8'hff);        // status is read-only
    reg_write(REG_OAMADDR, 8'hff);
    reg_write(REG_OAMDATA, 8'hab);       // pointer wraps to 0
    reg_read(REG_OAMDATA);
    reg_write(REG_SCROLL, 8'h80);
    reg_write(REG_SCROLL, 8'h7f);
    // palette mirror entry 0x10 lands on 0x00
    set_vaddr(14'h3f10);
    reg_write(REG_DATA, 8'h5a);
    set_vaddr(14'h3f00);
    reg_read(REG_DATA);
    // 0x3000 range: writes dropped, reads return 0 and keep the buffer
    set_vaddr(14'h3000);
    reg_write(REG_DATA, 8'hee);
    reg_read(REG_DATA);
    // top of pattern space, then the buffer carries it into name-table space
    set_vaddr(14'h1fff);
    data_read();
    data_read();
    data_read();
    // step of 32 and wrap of the 14-bit address
    reg_write(REG_CTRL, 8'h04);
    set_vaddr(14'h3fff);
    reg_write(REG_DATA, 8'h11);
    data_read();
    reg_write(REG_CTRL, 8'h00);
    for (int s = 0; s < 7; s++) reg_read(s[2:0]);
    data_read();
  endtask

  // Name-table traffic under every mirroring setting
  task automatic test_mirroring();
    logic [1:0] modes [4];
    modes = '{MIR_HORIZ, MIR_VERT, MIR_FOUR, MIR_NONE};
    foreach (modes[m]) begin
      set_mirroring(modes[m]);
      for (int k = 0; k < 2; k++) begin
        set_vaddr(14'(14'h2000 + $urandom_range(0, 'hfff)));
        reg_write(REG_DATA, 8'($urandom));
        set_vaddr(14'(14'h2000 + $urandom_range(0, 'hfff)));
        data_read();
        data_read();
      end
    end
    set_mirroring(MIR_HORIZ);
  endtask

  // Run a full frame: vblank, NMI, sprite-zero hit and frame wrap
  task automatic test_frame();
    int start;
    start = frames_seen;
    reg_write(REG_MASK, 8'h10);
    reg_write(REG_OAMADDR, 8'h00);
    reg_write(REG_OAMDATA, 8'($urandom_range(2, 40)));
    reg_write(REG_OAMDATA, 8'($urandom));
    reg_write(REG_OAMDATA, 8'($urandom));
    reg_write(REG_OAMDATA, 8'($urandom_range(0, 200)));
    reg_write(REG_CTRL, 8'h80);
    quiet = ($urandom_range(0, 1) == 1);
    while (frames_seen == start) begin
      case ($urandom_range(0, 19))
        0: reg_read(REG_STATUS);
        1: send_word(OP_ACK, 3'($urandom), 8'($urandom), 8'($urandom), 13'($urandom));
        2: reg_write(REG_CTRL, {$urandom_range(0, 1) == 1, 7'd0});
        default: tick(8'($urandom_range(180, 255)));
      endcase
    end
    quiet = 1'b0;
  endtask

  // Random sequences: mostly well-formed register sequences, some noise
  task automatic test_random(int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 11);
      case (kind)
        0, 1: tick(8'($urandom));
        2: begin                          // address pair then data accesses
          set_vaddr(14'($urandom));
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1)) data_read(); else reg_write(REG_DATA, 8'($urandom));
          end
        end
        3: begin
          reg_write(REG_OAMADDR, 8'($urandom));
          repeat ($urandom_range(1, 3)) reg_write(REG_OAMDATA, 8'($urandom));
          reg_read(REG_OAMDATA);
        end
        4: begin
          reg_write(REG_SCROLL, 8'($urandom));
          reg_write(REG_SCROLL, 8'($urandom));
        end
        5: reg_write(REG_CTRL, 8'($urandom));
        6: reg_write(REG_MASK, 8'($urandom));
        7: reg_read(REG_STATUS);
        8: send_word(OP_LOAD, 3'($urandom), 8'($urandom), 8'($urandom), 13'($urandom));
        9: send_word(OP_ACK, 3'($urandom), 8'($urandom), 8'($urandom), 13'($urandom));
        10: begin                          // broken or stray register access
          if ($urandom_range(0, 1)) reg_write(3'($urandom), 8'($urandom));
          else if (vaddr > 14'h1fff) reg_read(3'($urandom));
          else reg_read(3'($urandom_range(0, 6)));
        end
        default: send_word(3'(OP_SPARE + $urandom_range(0, 2)), 3'($urandom),
                           8'($urandom), 8'($urandom), 13'($urandom));
      endcase
      if (i == n / 3) set_mirroring(MIR_VERT);
      if (i == 2 * n / 3) set_mirroring(MIR_FOUR);
    end
  endtask

  initial begin
    errors         = 0;
    quiet          = 1'b0;
    frames_seen    = 0;
    mir_sel        = MIR_HORIZ;
    ctrl_r         = '0;
    mask_r         = '0;
    oam_ptr        = '0;
    scroll_x_r     = '0;
    scroll_y_r     = '0;
    data_buf       = '0;
    vblank         = 1'b0;
    spr0_hit       = 1'b0;
    nmi_req        = 1'b0;
    addr_lo_next   = 1'b0;
    scroll_y_next  = 1'b0;
    vaddr          = '0;
    dot_cnt        = 0;
    line_cnt       = 0;
    foreach (oam_mem[i]) oam_mem[i] = '0;
    foreach (nt_mem[i]) nt_mem[i] = '0;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    foreach (chr_mem[i]) begin
      chr_mem[i]   = '0;
      chr_known[i] = 1'b0;
    end

    rst            <= 1'b1;
    push           <= 1'b0;
    op             <= OP_TICK;
    reg_sel        <= REG_CTRL;
    wdata          <= '0;
    tick_cycles    <= '0;
    chr_index      <= '0;
    mirroring_we   <= 1'b0;
    mirroring_mode <= MIR_HORIZ;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_mirroring(MIR_HORIZ);
    test_directed();
    test_mirroring();
    test_frame();
    test_random(60);

    drain();
    if (errors == 0) begin
      $display("PASS video_register_port_timing_core");
    end else begin
      $display("FAIL video_register_port_timing_core");
    end
    $finish;
  end

  // Watchdog, well past the slowest legal run including the reset sweep
  initial begin
    #4000000;
    $display("FAIL video_register_port_timing_core");
    $finish;
  end

endmodule

/* filelist.f */
src/vrpt_pkg.sv
src/vrpt_fifo.sv
src/vrpt_front.sv
src/vrpt_back.sv
src/video_register_port_timing_core.sv
dv/video_register_port_timing_core_tb.sv
